FILE: hw/rtl/rdol_pkg.sv
// Package for the ring descriptor offset lookup block.
// Holds request/response payload types, action codes and the control/status
// structs shared by the controller and datapath. Depends on nothing.
package rdol_pkg;

   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 16;
   localparam int OFFSET_W = 20;
   localparam int INDEX_W  = 4;

   // request action codes
   localparam logic ACTION_ADD  = 1'b0;
   localparam logic ACTION_FIND = 1'b1;

   typedef struct packed {
      logic                action;
      logic [ADDR_W-1:0]   entry_address;
      logic [LEN_W-1:0]    entry_length;
      logic [OFFSET_W-1:0] search_offset;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] slot_index;
      logic [ADDR_W-1:0]  found_address;
      logic [LEN_W-1:0]   found_length;
      logic [LEN_W-1:0]   byte_in_entry;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic add;    // store descriptor, advance pointers
      logic load;   // start a walk at the oldest slot
      logic step;   // move to the next slot, take its length off
      logic hit;    // capture the current slot as the response
      logic miss;   // capture a not-found response
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic empty;  // ring holds no descriptor
      logic hit;    // remaining offset falls inside the current slot
      logic last;   // current slot is the newest one
   } sts_type;

endpackage

FILE: hw/rtl/rdol_datapath.sv
// Datapath of the ring descriptor offset lookup block: descriptor memory,
// ring pointers, walk registers and the response register.
// Depends on rdol_pkg.
module rdol_datapath
   import rdol_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] n;
      n = (s == LAST_SLOT) ? '0 : s + 1'b1;
      return n;
   endfunction

   // descriptor storage, no reset
   logic [ADDR_W-1:0] addr_mem [DEPTH];
   logic [LEN_W-1:0]  len_mem  [DEPTH];

   logic [SLOT_W-1:0]   write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0]   oldest_slot_ff, oldest_slot_in;
   logic                ring_full_ff, ring_full_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic [OFFSET_W-1:0] remain_ff, remain_in;
   logic [ADDR_W-1:0]   rd_addr_data_ff;
   logic [LEN_W-1:0]    rd_len_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic [SLOT_W-1:0]   idx_next;
   logic [OFFSET_W-1:0] len_ext;

   assign idx_next = next_slot(idx_ff);
   assign len_ext  = OFFSET_W'(rd_len_ff);

   // status toward the controller
   assign sts.empty = (write_slot_ff == oldest_slot_ff) && !ring_full_ff;
   assign sts.hit   = remain_ff < len_ext;
   assign sts.last  = idx_next == write_slot_ff;

   // advance ring pointers on an add
   always_comb begin
      write_slot_in  = write_slot_ff;
      oldest_slot_in = oldest_slot_ff;
      ring_full_in   = ring_full_ff;
      if (cmd.add) begin
         write_slot_in  = next_slot(write_slot_ff);
         oldest_slot_in = ring_full_ff ? next_slot(oldest_slot_ff) : oldest_slot_ff;
         if (write_slot_in == oldest_slot_in) begin
            ring_full_in = 1'b1;
         end
      end
   end

   // walk index and remaining offset; the index also addresses the read port
   always_comb begin
      idx_in    = idx_ff;
      remain_in = remain_ff;
      if (cmd.load) begin
         idx_in    = oldest_slot_ff;
         remain_in = req_data.search_offset;
      end else if (cmd.step) begin
         idx_in    = idx_next;
         remain_in = remain_ff - len_ext;
      end
   end

   // build the response
   always_comb begin
      rsp_valid_in = cmd.hit || cmd.miss;
      rsp_in       = rsp_ff;
      if (cmd.hit) begin
         rsp_in.found         = 1'b1;
         rsp_in.slot_index    = INDEX_W'(idx_ff);
         rsp_in.found_address = rd_addr_data_ff;
         rsp_in.found_length  = rd_len_ff;
         rsp_in.byte_in_entry = remain_ff[LEN_W-1:0];
      end else if (cmd.miss) begin
         rsp_in = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff  <= '0;
         oldest_slot_ff <= '0;
         ring_full_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         write_slot_ff  <= write_slot_in;
         oldest_slot_ff <= oldest_slot_in;
         ring_full_ff   <= ring_full_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      remain_ff <= remain_in;
      rsp_ff    <= rsp_in;
   end

   // descriptor memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.add) begin
         addr_mem[write_slot_ff] <= req_data.entry_address;
         len_mem[write_slot_ff]  <= req_data.entry_length;
      end
      rd_addr_data_ff <= addr_mem[idx_in];
      rd_len_ff       <= len_mem[idx_in];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hw/rtl/rdol_controller.sv
// Controller of the ring descriptor offset lookup block: accepts requests
// and sequences the descriptor walk of a find. Depends on rdol_pkg.
module rdol_controller
   import rdol_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    req_action,
   input  sts_type sts,
   output logic    busy,
   output cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic state_ff, state_in;

   // decode the next state and the datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_action == ACTION_ADD) begin
                  cmd.add = 1'b1;
               end else if (sts.empty) begin
                  cmd.miss = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (sts.hit) begin
               cmd.hit  = 1'b1;
               state_in = ST_IDLE;
            end else if (sts.last) begin
               cmd.miss = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff == ST_WALK;

endmodule

FILE: hw/rtl/ring_descriptor_offset_lookup.sv
// Ring descriptor offset lookup. An add gives no response.
// A find walks one descriptor per cycle from the oldest slot, visiting
// 1..DEPTH slots, and strobes its response once the walk hits or reaches
// the newest slot. A find on an empty ring responds in the next cycle,
// without a walk. The receiver cannot stall. Reset empties the ring;
// descriptor storage is not cleared.
module ring_descriptor_offset_lookup
   import rdol_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;
   logic    busy_int;

   // gate requests so only idle-cycle starts are accepted
   rdol_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_data.action),
      .sts        (sts),
      .busy       (busy_int),
      .cmd        (cmd)
   );

   rdol_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign busy = busy_int;

endmodule

FILE: hw/rtl/rdol_checker.sv
// Port-level checks for the ring descriptor offset lookup block, bound to
// the top level. Depends on rdol_pkg.
module rdol_checker
   import rdol_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // a not-found response carries all-zero fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |->
         rsp_data.slot_index == '0 && rsp_data.found_address == '0 &&
         rsp_data.found_length == '0 && rsp_data.byte_in_entry == '0)
      else $error("not-found response with nonzero fields");

   // a match lies inside its descriptor
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> rsp_data.byte_in_entry < rsp_data.found_length)
      else $error("byte offset outside matched descriptor");

   // an add never produces a response and never starts a walk
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.action == ACTION_ADD |=> !rsp_valid && !busy)
      else $error("add produced a response or busy");

   // no response while a walk is still running
   assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("response during walk");

   // reset leaves the block idle and quiet
   assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("not idle after reset");

endmodule

bind ring_descriptor_offset_lookup rdol_checker u_rdol_checker (.*);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking testbench for ring_descriptor_offset_lookup.
// Sends descriptor adds and offset finds, predicts each find response in a small
// scoreboard class and compares it field by field. Depends on rdol_pkg and the RTL.

module tb_top;
   import rdol_pkg::*;

   localparam int RING_DEPTH   = 16;
   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 10;
   localparam int RANDOM_ITEMS = 1135;
   localparam int DRAIN_CYCLES = RING_DEPTH + 4;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_LIMIT = 10;

   // Track ring contents and queue the response each find must produce.
   class ring_lookup_scoreboard;
      logic [ADDR_W-1:0]  address_store[RING_DEPTH];
      logic [LEN_W-1:0]   length_store[RING_DEPTH];
      logic [INDEX_W-1:0] write_slot;
      logic [INDEX_W-1:0] oldest_slot;
      bit                 ring_full;
      rsp_type            expected_lookups[$];
      int                 mismatch_count;

      function new();
         foreach (address_store[i]) begin
            address_store[i] = '0;
            length_store[i]  = '0;
         end
         write_slot     = '0;
         oldest_slot    = '0;
         ring_full      = 1'b0;
         mismatch_count = 0;
      endfunction

      function logic [INDEX_W-1:0] next_slot(logic [INDEX_W-1:0] s);
         return (int'(s) == RING_DEPTH - 1) ? '0 : s + 1'b1;
      endfunction

      function bit ring_empty();
         return (write_slot == oldest_slot) && !ring_full;
      endfunction

      // Walk oldest to newest, taking each length off the offset.
      function rsp_type lookup_offset(logic [OFFSET_W-1:0] offset);
         rsp_type            r;
         int unsigned        remain;
         logic [INDEX_W-1:0] idx;
         r = '0;
         if (ring_empty())
            return r;
         remain = 32'(offset);
         idx    = oldest_slot;
         for (int n = 0; n < RING_DEPTH; n++) begin
            if (remain < length_store[idx]) begin
               r.found         = 1'b1;
               r.slot_index    = idx;
               r.found_address = address_store[idx];
               r.found_length  = length_store[idx];
               r.byte_in_entry = remain[LEN_W-1:0];
               return r;
            end
            remain = remain - length_store[idx];
            idx    = next_slot(idx);
            if (idx == write_slot)
               break;
         end
         return r;
      endfunction

      // Sum of all stored lengths, used to aim find offsets.
      function int unsigned stored_bytes();
         int unsigned        sum;
         logic [INDEX_W-1:0] idx;
         sum = 0;
         if (ring_empty())
            return sum;
         idx = oldest_slot;
         do begin
            sum = sum + length_store[idx];
            idx = next_slot(idx);
         end while (idx != write_slot);
         return sum;
      endfunction

      // Apply an accepted request: store on add, queue a prediction on find.
      function void note_request(req_type req);
         if (req.action == ACTION_ADD) begin
            address_store[write_slot] = req.entry_address;
            length_store[write_slot]  = req.entry_length;
            write_slot = next_slot(write_slot);
            if (ring_full)
               oldest_slot = next_slot(oldest_slot);
            if (write_slot == oldest_slot)
               ring_full = 1'b1;
         end else begin
            expected_lookups.push_back(lookup_offset(req.search_offset));
         end
      endfunction

      // Compare a strobed response with the oldest pending prediction.
      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_lookups.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: response with no find pending: found=%0b slot=%0d addr=%h",
                        $realtime, got.found, got.slot_index, got.found_address);
            return;
         end
         want = expected_lookups.pop_front();
         if (got.found !== want.found || got.slot_index !== want.slot_index ||
             got.found_address !== want.found_address ||
             got.found_length !== want.found_length ||
             got.byte_in_entry !== want.byte_in_entry) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: lookup mismatch: expected found=%0b slot=%0d addr=%h %s",
                        $realtime, want.found, want.slot_index, want.found_address,
                        $sformatf("len=%0d byte=%0d", want.found_length,
                                  want.byte_in_entry));
               $display("%0t:   got found=%0b slot=%0d addr=%h len=%0d byte=%0d",
                        $realtime, got.found, got.slot_index, got.found_address,
                        got.found_length, got.byte_in_entry);
            end
         end
      endfunction
   endclass

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   ring_lookup_scoreboard sb;
   int                    sender_idle_pct = 25;
   int                    cycle_count     = 0;

   ring_descriptor_offset_lookup #(
      .DEPTH(RING_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Sample handshakes at the rising edge: responses first, then new requests.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1)
            sb.check_response(rsp_data);
         if (start === 1'b1 && busy === 1'b0)
            sb.note_request(req_data);
      end
   end

   // Bound the run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   function automatic req_type add_request(logic [ADDR_W-1:0] address,
                                           logic [LEN_W-1:0] length);
      req_type r;
      r.action        = ACTION_ADD;
      r.entry_address = address;
      r.entry_length  = length;
      r.search_offset = OFFSET_W'($urandom_range((1 << OFFSET_W) - 1));
      return r;
   endfunction

   function automatic req_type find_request(logic [OFFSET_W-1:0] offset);
      req_type r;
      r.action        = ACTION_FIND;
      r.entry_address = $urandom;
      r.entry_length  = LEN_W'($urandom_range((1 << LEN_W) - 1));
      r.search_offset = offset;
      return r;
   endfunction

   // Idle at random, then hold the request until the block takes it.
   task automatic send_request(input req_type req);
      while ($urandom_range(99) < sender_idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start    = 1'b1;
      req_data = req;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Hold off until every pending find has answered, then let the block settle.
   task automatic drain_lookups();
      start = 1'b0;
      while (sb.expected_lookups.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      int unsigned       total;
      logic [LEN_W-1:0]  length;
      logic [OFFSET_W-1:0] offset;

      sb = new();
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // Empty ring: any offset misses.
      send_request(find_request('0));
      send_request(find_request('1));
      // Zero-length entry, minimum and maximum lengths, extreme handles.
      send_request(add_request('1, '0));
      send_request(add_request('0, 16'd1));
      send_request(add_request(32'hA5A5_5A5A, '1));
      // Walk skips the zero-length entry; hit first and last bytes.
      send_request(find_request(20'd0));
      send_request(find_request(20'd1));
      send_request(find_request(20'h0FFFF));
      // Offset at and past the end of the data.
      send_request(find_request(20'h10000));
      send_request(find_request('1));
      // Trailing zero-length entry still leaves the end unmatched.
      send_request(add_request(32'h1234_5678, '0));
      send_request(find_request(20'h10000));
      send_request(find_request(20'h0FFFE));
      drain_lookups();

      // Random mix in three idle phases.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3) begin
            drain_lookups();
            sender_idle_pct = 62;
         end else if (i == 2 * RANDOM_ITEMS / 3) begin
            drain_lookups();
            sender_idle_pct = 0;
         end
         if ($urandom_range(99) < 45) begin
            case ($urandom_range(9))
               0:       length = '0;
               1:       length = '1;
               2, 3:    length = LEN_W'($urandom_range((1 << LEN_W) - 1));
               default: length = LEN_W'($urandom_range(1, 40));
            endcase
            send_request(add_request($urandom, length));
         end else begin
            total = sb.stored_bytes();
            case ($urandom_range(9))
               0:       offset = total[OFFSET_W-1:0];
               1:       offset = OFFSET_W'($urandom_range((1 << OFFSET_W) - 1));
               2:       offset = (total == 0) ? '0 : OFFSET_W'(total - 1);
               default: offset = (total == 0) ? '0 : OFFSET_W'($urandom_range(total - 1));
            endcase
            send_request(find_request(offset));
         end
      end

      drain_lookups();
      if (sb.mismatch_count == 0 && sb.expected_lookups.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
